// File: rtl/sfr_pkg.sv
`default_nettype none
package sfr_pkg;

   // configuration register map
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_CRC      = 1'b1;
   localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'hAA;
   localparam logic [31:0] IMAGE_CRC_RESET      = 32'h0000_0000;

   // frame bytes and command codes
   localparam logic [7:0] START_BYTE    = 8'hEF;
   localparam logic [7:0] CMD_PING      = 8'h00;
   localparam logic [7:0] CMD_CRC_QUERY = 8'h2C;
   localparam logic [7:0] RSP_CRC       = 8'h2D;
   localparam logic [7:0] CMD_PIN_STATE = 8'h98;
   localparam logic [7:0] PAD_BYTE      = 8'h00;

   // reply length field values
   localparam logic [7:0] LEN_PING = 8'd0;
   localparam logic [7:0] LEN_CRC  = 8'd4;
   localparam logic [7:0] LEN_PINS = 8'd6;

   // reply body sizes in words, check word excluded
   localparam int unsigned IDX_W = 4;
   localparam logic [IDX_W-1:0] BODY_PING = 4'd4;
   localparam logic [IDX_W-1:0] BODY_CRC  = 4'd8;
   localparam logic [IDX_W-1:0] BODY_PINS = 4'd10;

   typedef enum logic [1:0] {
      KIND_PING,
      KIND_CRC,
      KIND_PINS
   } kind_type;

   // one reply job handed from the parser to the reply sequencer
   typedef struct packed {
      kind_type    kind;
      logic [15:0] port_a;
      logic [15:0] port_b;
      logic [7:0]  port_c;
   } job_type;

endpackage
`default_nettype wire

// File: rtl/sfr_ifs.sv
`default_nettype none
interface sfr_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic [15:0] port_a_pins;
   logic [15:0] port_b_pins;
   logic [7:0]  port_c_pins;
   modport source(output valid, rx_byte, port_a_pins, port_b_pins, port_c_pins,
                  input ready);
   modport sink(input valid, rx_byte, port_a_pins, port_b_pins, port_c_pins,
                output ready);
endinterface

interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_last;
   modport source(output valid, tx_byte, tx_last, input ready);
   modport sink(input valid, tx_byte, tx_last, output ready);
endinterface
`default_nettype wire

// File: rtl/sfr_front.sv
`default_nettype none
module sfr_front (
   input  wire logic      clock,
   input  wire logic      reset,
   sfr_req_if.sink        req_bus,
   input  wire logic      queue_full,
   output logic           push,
   output sfr_pkg::job_type push_job
);

   logic [8:0] byte_count_ff, byte_count_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] command_code_ff, command_code_in;
   logic [7:0] running_check_ff, running_check_in;
   logic       accept;
   logic       known;
   sfr_pkg::kind_type kind;

   assign req_bus.ready = !queue_full;
   assign accept = req_bus.valid && !queue_full;

   // command decode
   always_comb begin
      known = 1'b1;
      kind  = sfr_pkg::KIND_PING;
      case (command_code_ff)
         sfr_pkg::CMD_PING:      kind = sfr_pkg::KIND_PING;
         sfr_pkg::CMD_CRC_QUERY: kind = sfr_pkg::KIND_CRC;
         sfr_pkg::CMD_PIN_STATE: kind = sfr_pkg::KIND_PINS;
         default:                known = 1'b0;
      endcase
   end

   assign push_job.kind   = kind;
   assign push_job.port_a = req_bus.port_a_pins;
   assign push_job.port_b = req_bus.port_b_pins;
   assign push_job.port_c = req_bus.port_c_pins;

   always_comb begin
      byte_count_in    = byte_count_ff;
      frame_length_in  = frame_length_ff;
      command_code_in  = command_code_ff;
      running_check_in = running_check_ff;
      push             = 1'b0;
      if (accept) begin
         if (byte_count_ff == 9'd0) begin
            if (req_bus.rx_byte == sfr_pkg::START_BYTE) begin
               running_check_in = req_bus.rx_byte;
               byte_count_in    = 9'd1;
            end
         end else if (byte_count_ff >= 9'd4 &&
                      byte_count_ff == ({1'b0, frame_length_ff} + 9'd4)) begin
            // check word: good check and known command queue a reply
            push             = (req_bus.rx_byte == running_check_ff) && known;
            byte_count_in    = 9'd0;
            frame_length_in  = 8'd0;
            command_code_in  = 8'd0;
            running_check_in = 8'd0;
         end else begin
            if (byte_count_ff == 9'd2) begin
               frame_length_in = req_bus.rx_byte;
            end
            if (byte_count_ff == 9'd3) begin
               command_code_in = req_bus.rx_byte;
            end
            running_check_in = running_check_ff ^ req_bus.rx_byte;
            byte_count_in    = byte_count_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff    <= 9'd0;
         frame_length_ff  <= 8'd0;
         command_code_ff  <= 8'd0;
         running_check_ff <= 8'd0;
      end else begin
         byte_count_ff    <= byte_count_in;
         frame_length_ff  <= frame_length_in;
         command_code_ff  <= command_code_in;
         running_check_ff <= running_check_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/sfr_queue.sv
`default_nettype none
module sfr_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire sfr_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output sfr_pkg::job_type      head_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   sfr_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/sfr_back.sv
`default_nettype none
module sfr_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire sfr_pkg::job_type job,
   input  wire logic [7:0]       device_address,
   input  wire logic [31:0]      image_crc,
   output logic                  pop,
   sfr_rsp_if.source             rsp_bus
);

   logic [sfr_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]                chk_ff, chk_in;
   logic                      valid_ff, valid_in;
   logic [7:0]                tx_byte_ff, tx_byte_in;
   logic                      tx_last_ff, tx_last_in;
   logic [sfr_pkg::IDX_W-1:0] body_len;
   logic [7:0]                len_field;
   logic [7:0]                code_field;
   logic [7:0]                body_byte;
   logic [7:0]                cur_byte;
   logic                      is_chk;
   logic                      load;

   assign rsp_bus.valid   = valid_ff;
   assign rsp_bus.tx_byte = tx_byte_ff;
   assign rsp_bus.tx_last = tx_last_ff;

   always_comb begin
      case (job.kind)
         sfr_pkg::KIND_CRC: begin
            body_len   = sfr_pkg::BODY_CRC;
            len_field  = sfr_pkg::LEN_CRC;
            code_field = sfr_pkg::RSP_CRC;
         end
         sfr_pkg::KIND_PINS: begin
            body_len   = sfr_pkg::BODY_PINS;
            len_field  = sfr_pkg::LEN_PINS;
            code_field = sfr_pkg::CMD_PIN_STATE;
         end
         default: begin
            body_len   = sfr_pkg::BODY_PING;
            len_field  = sfr_pkg::LEN_PING;
            code_field = sfr_pkg::CMD_PING;
         end
      endcase
   end

   // payload words by position; pin words only matter for pin replies
   always_comb begin
      case (idx_ff)
         4'd0:    body_byte = sfr_pkg::START_BYTE;
         4'd1:    body_byte = device_address;
         4'd2:    body_byte = len_field;
         4'd3:    body_byte = code_field;
         4'd4:    body_byte = (job.kind == sfr_pkg::KIND_CRC) ? image_crc[7:0]
                                                            : job.port_a[7:0];
         4'd5:    body_byte = (job.kind == sfr_pkg::KIND_CRC) ? image_crc[15:8]
                                                            : job.port_a[15:8];
         4'd6:    body_byte = (job.kind == sfr_pkg::KIND_CRC) ? image_crc[23:16]
                                                            : job.port_b[7:0];
         4'd7:    body_byte = (job.kind == sfr_pkg::KIND_CRC) ? image_crc[31:24]
                                                            : job.port_b[15:8];
         4'd8:    body_byte = job.port_c;
         4'd9:    body_byte = sfr_pkg::PAD_BYTE;
         default: body_byte = sfr_pkg::PAD_BYTE;
      endcase
   end

   assign is_chk   = (idx_ff == body_len);
   assign cur_byte = is_chk ? chk_ff : body_byte;
   assign load     = job_valid && (!valid_ff || rsp_bus.ready);

   always_comb begin
      idx_in     = idx_ff;
      chk_in     = chk_ff;
      valid_in   = valid_ff;
      tx_byte_in = tx_byte_ff;
      tx_last_in = tx_last_ff;
      pop        = 1'b0;
      if (load) begin
         valid_in   = 1'b1;
         tx_byte_in = cur_byte;
         tx_last_in = is_chk;
         if (is_chk) begin
            idx_in = '0;
            chk_in = 8'd0;
            pop    = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
            chk_in = chk_ff ^ body_byte;
         end
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      tx_byte_ff <= tx_byte_in;
      tx_last_ff <= tx_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         chk_ff   <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         chk_ff   <= chk_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/serial_frame_responder_core.sv
`default_nettype none
// channel   dir  handshake        payload
// req_bus   in   valid / ready    rx_byte, port_a_pins, port_b_pins, port_c_pins
// rsp_bus   out  valid / ready    tx_byte, tx_last
// csr_*     in   csr_we           csr_index, csr_wdata (no read-back)
//
// the parser takes one word per cycle and only stalls when the reply queue is full
// the reply sequencer sends one word per cycle while rsp_bus.ready holds: 5, 9 or 11 words per reply
// a frame's check word queues its reply; with the sequencer idle the queue entry is
// registered first, then the first reply word is loaded into the output register
// input stalls only while QUEUE_DEPTH replies are held, the one being sent included
// synchronous reset: parser back to hunting, queue empty, address 0xAA, crc 0
module serial_frame_responder_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   sfr_req_if.sink                               req_bus,
   sfr_rsp_if.source                             rsp_bus,
   input  wire logic                             csr_we,
   input  wire logic [sfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // configuration registers
   logic [7:0]  device_address_ff;
   logic [31:0] image_crc_ff;

   // parser to queue
   logic             push;
   sfr_pkg::job_type push_job;
   logic             queue_full;

   // queue to sequencer
   logic             queue_empty;
   logic             pop;
   sfr_pkg::job_type head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= sfr_pkg::DEVICE_ADDRESS_RESET;
         image_crc_ff      <= sfr_pkg::IMAGE_CRC_RESET;
      end else if (csr_we) begin
         if (csr_index == sfr_pkg::CSR_DEVICE_ADDRESS) begin
            device_address_ff <= csr_wdata[7:0];
         end
         if (csr_index == sfr_pkg::CSR_IMAGE_CRC) begin
            image_crc_ff <= csr_wdata[31:0];
         end
      end
   end

   // front: frame hunt, length/command capture, running check
   sfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // pending replies, each with the pin levels of its check word
   sfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   // back: reply word sequencer with output register
   sfr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (!queue_empty),
      .job            (head_job),
      .device_address (device_address_ff),
      .image_crc      (image_crc_ff),
      .pop            (pop),
      .rsp_bus        (rsp_bus)
   );

endmodule
`default_nettype wire
